/* src/fixed_block_pool_allocator_assert.svh */
// ----------------------------------------------------------------------------
// fixed block pool allocator assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FBPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define FBPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fbpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// types, widths and codes shared by the block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // pool capacity and derived widths
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_BLOCKS);

  // index divider step counter
  localparam int STEP_W     = $clog2(IDX_W + 1);

  // field widths
  localparam int ADDR_W    = 32;
  localparam int WORDS_W   = 14;
  localparam int BYTES_W   = WORDS_W + 2;
  localparam int CNT_W     = 9;
  localparam int USED_W    = 9;
  localparam int SPAN_W    = CNT_W + BYTES_W;
  localparam int REM_W     = BYTES_W + IDX_W;
  localparam int PROD_W    = IDX_W + BYTES_W;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORDS  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd3;

  // commands
  localparam logic CMD_GET     = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_POOL = 2'd2,
    ST_BAD_PTR  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_CHK,
    S_DIV,
    S_PUSH,
    S_MUL,
    S_OUT
  } fsm_t;

  // pool setup as seen by the datapath
  typedef struct packed {
    logic                enabled;
    logic [ADDR_W-1:0]   base;
    logic [BYTES_W-1:0]  bytes;
    logic [CNT_W-1:0]    cnt;
    logic [SPAN_W-1:0]   span;
    logic                rebuild;
  } cfg_t;

  // link memory access
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [LINK_W-1:0] wr_link;
    logic              clear;
  } link_req_t;

endpackage

/* src/fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// equal-size block pool with a lifo free list held in a link memory
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one item is a get or a release;
//   a release carries any byte address inside the block being returned.
//   output channel (out_valid / out_stall): exactly one result item per
//   input item, in order: block address, status, used count, head valid.
//   config port (cfg_*): apb-style, four 32-bit registers at 0x0..0xc,
//   pready always high; each write rebuilds the free list in order and
//   clears the used count; the input is held off in the access cycle and
//   the cycle after it.
// steps from the accept edge to out_valid:
//   get: link memory read and head update, index multiply, output
//   release: pool check, eight-step one-bit-per-cycle index divider, push,
//   index multiply, output; disabled pool or empty list: output only;
//   address outside the pool: pool check, output
// one item is worked on at a time; the next is taken only after the result
// is written to the output register and the block is back in idle.
// reset clears the pool setup to its defaults and rebuilds the list at once.
// while out_stall holds, the finished result waits in the output register
// and the block takes no further result until it leaves.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [31:0]                  in_release_address,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  out_block_address,
  output logic [1:0]                   out_status,
  output logic [8:0]                   out_used_count,
  output logic                         out_head_valid,
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  fbpa_pkg::cfg_t      cfg;
  fbpa_pkg::link_req_t link_req;
  fbpa_pkg::fsm_t      state_r;
  fbpa_pkg::fsm_t      state_nxt;
  fbpa_pkg::status_t   status_r;
  fbpa_pkg::status_t   status_acc;

  logic [fbpa_pkg::LINK_W-1:0] head_r;
  logic [fbpa_pkg::USED_W-1:0] used_r;
  logic [fbpa_pkg::IDX_W-1:0]  idx_r;
  logic [fbpa_pkg::ADDR_W-1:0] off_r;
  logic [fbpa_pkg::PROD_W-1:0] prod_r;
  logic                        out_valid_r;
  logic [fbpa_pkg::ADDR_W-1:0] out_block_address_r;
  fbpa_pkg::status_t           out_status_r;
  logic [fbpa_pkg::USED_W-1:0] out_used_count_r;
  logic                        out_head_valid_r;

  logic [fbpa_pkg::LINK_W-1:0] rd_link;
  logic                        rd_written;
  logic [fbpa_pkg::LINK_W-1:0] link_dflt;
  logic [fbpa_pkg::LINK_W-1:0] link_nxt;
  logic                        head_empty;
  logic                        in_pool;
  logic                        in_accept;
  logic                        cfg_wr_now;
  logic                        div_start;
  logic                        div_done;
  logic [fbpa_pkg::IDX_W-1:0]  div_q;
  logic                        out_load;

  // configuration registers
  fbpa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // free list links
  fbpa_link_mem u_link_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (link_req),
    .rd_link    (rd_link),
    .rd_written (rd_written)
  );

  // offset to block index
  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_r[fbpa_pkg::REM_W-1:0]),
    .divisor  (cfg.bytes),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr_now = cfg_psel & cfg_penable & cfg_pwrite;

  // list status and link fallback for entries not yet written
  always_comb begin
    head_empty = (head_r >= fbpa_pkg::LINK_W'(cfg.cnt));
    in_pool    = (off_r < fbpa_pkg::ADDR_W'(cfg.span));
    link_dflt  = fbpa_pkg::LINK_W'(idx_r) + fbpa_pkg::LINK_W'(1);
    if (link_dflt >= fbpa_pkg::LINK_W'(cfg.cnt)) begin
      link_dflt = fbpa_pkg::LINK_END;
    end
    link_nxt = rd_written ? rd_link : link_dflt;
  end

  // early verdict on an item as it is taken
  always_comb begin
    if (!cfg.enabled) begin
      status_acc = fbpa_pkg::ST_BAD_POOL;
    end else if (in_command == fbpa_pkg::CMD_GET && head_empty) begin
      status_acc = fbpa_pkg::ST_EMPTY;
    end else begin
      status_acc = fbpa_pkg::ST_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (in_accept) begin
          if (status_acc != fbpa_pkg::ST_OK) begin
            state_nxt = fbpa_pkg::S_OUT;
          end else if (in_command == fbpa_pkg::CMD_GET) begin
            state_nxt = fbpa_pkg::S_GET;
          end else begin
            state_nxt = fbpa_pkg::S_CHK;
          end
        end
      end
      fbpa_pkg::S_GET:  state_nxt = fbpa_pkg::S_MUL;
      fbpa_pkg::S_CHK:  state_nxt = in_pool ? fbpa_pkg::S_DIV : fbpa_pkg::S_OUT;
      fbpa_pkg::S_DIV:  state_nxt = div_done ? fbpa_pkg::S_PUSH : fbpa_pkg::S_DIV;
      fbpa_pkg::S_PUSH: state_nxt = fbpa_pkg::S_MUL;
      fbpa_pkg::S_MUL:  state_nxt = fbpa_pkg::S_OUT;
      fbpa_pkg::S_OUT:  state_nxt = out_load ? fbpa_pkg::S_IDLE : fbpa_pkg::S_OUT;
      default:          state_nxt = fbpa_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake, memory access, divider start
  always_comb begin
    in_stall  = (state_r != fbpa_pkg::S_IDLE) | cfg.rebuild | cfg_wr_now;
    in_accept = in_valid & ~in_stall;
    out_load  = (state_r == fbpa_pkg::S_OUT) & (~out_valid_r | ~out_stall);
    div_start = (state_r == fbpa_pkg::S_CHK) & in_pool;

    link_req.rd_en   = in_accept & (status_acc == fbpa_pkg::ST_OK) &
                       (in_command == fbpa_pkg::CMD_GET);
    link_req.rd_idx  = head_r[fbpa_pkg::IDX_W-1:0];
    link_req.wr_en   = (state_r == fbpa_pkg::S_PUSH);
    link_req.wr_idx  = idx_r;
    link_req.wr_link = head_r;
    link_req.clear   = cfg.rebuild;
  end

  // control registers: state, list head, used count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::S_IDLE;
      head_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg.rebuild) begin
        head_r <= (cfg.cnt == '0) ? fbpa_pkg::LINK_END : '0;
        used_r <= '0;
      end else begin
        case (state_r)
          fbpa_pkg::S_GET: begin
            head_r <= link_nxt;
            if (used_r < fbpa_pkg::USED_W'(cfg.cnt)) begin
              used_r <= used_r + fbpa_pkg::USED_W'(1);
            end
          end
          fbpa_pkg::S_PUSH: begin
            head_r <= fbpa_pkg::LINK_W'(idx_r);
            if (used_r != '0) begin
              used_r <= used_r - fbpa_pkg::USED_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // item payload through the steps
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r <= status_acc;
      idx_r    <= head_r[fbpa_pkg::IDX_W-1:0];
      off_r    <= in_release_address - cfg.base;
    end
    case (state_r)
      fbpa_pkg::S_CHK: begin
        if (!in_pool) begin
          status_r <= fbpa_pkg::ST_BAD_PTR;
        end
      end
      fbpa_pkg::S_DIV: begin
        if (div_done) begin
          idx_r <= div_q;
        end
      end
      fbpa_pkg::S_MUL: begin
        prod_r <= fbpa_pkg::PROD_W'(idx_r) * fbpa_pkg::PROD_W'(cfg.bytes);
      end
      fbpa_pkg::S_OUT: begin
        if (out_load) begin
          out_block_address_r <= (status_r == fbpa_pkg::ST_OK) ?
                                 cfg.base + fbpa_pkg::ADDR_W'(prod_r) : '0;
          out_status_r        <= status_r;
          out_used_count_r    <= used_r;
          out_head_valid_r    <= ~head_empty;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_block_address_r;
  assign out_status        = out_status_r;
  assign out_used_count    = out_used_count_r;
  assign out_head_valid    = out_head_valid_r;

endmodule

/* src/fbpa_link_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_link_mem
// free list link memory with registered read and per-entry written flags
// ----------------------------------------------------------------------------
module fbpa_link_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbpa_pkg::link_req_t         req,
  output logic [fbpa_pkg::LINK_W-1:0] rd_link,
  output logic                        rd_written
);

  logic [fbpa_pkg::LINK_W-1:0]   mem_r [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::MAX_BLOCKS-1:0] written_r;
  logic [fbpa_pkg::LINK_W-1:0]   rd_link_r;
  logic                          rd_written_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_idx] <= req.wr_link;
    end
    if (req.rd_en) begin
      rd_link_r <= mem_r[req.rd_idx];
    end
  end

  // written flags, an unwritten entry falls back to the rebuilt order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (req.clear) begin
        written_r <= '0;
      end else if (req.wr_en) begin
        written_r[req.wr_idx] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written_r <= written_r[req.rd_idx];
      end
    end
  end

  assign rd_link    = rd_link_r;
  assign rd_written = rd_written_r;

endmodule

/* src/fbpa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_div
// restoring divider, one quotient bit per cycle, offset to block index
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fbpa_pkg::REM_W-1:0]   dividend,
  input  logic [fbpa_pkg::BYTES_W-1:0] divisor,
  output logic                         done,
  output logic [fbpa_pkg::IDX_W-1:0]   quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [fbpa_pkg::STEP_W-1:0]   step_r;
  logic [fbpa_pkg::REM_W-1:0]    rem_r;
  logic [fbpa_pkg::REM_W-1:0]    dsh_r;
  logic [fbpa_pkg::IDX_W-1:0]    quo_r;
  logic [fbpa_pkg::REM_W:0]      trial;

  // trial subtract of the aligned divisor
  assign trial = {1'b0, rem_r} - {1'b0, dsh_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + fbpa_pkg::STEP_W'(1);
        if (step_r == fbpa_pkg::STEP_W'(fbpa_pkg::IDX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= fbpa_pkg::REM_W'(divisor) << (fbpa_pkg::IDX_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (!trial[fbpa_pkg::REM_W]) begin
        rem_r <= trial[fbpa_pkg::REM_W-1:0];
      end
      quo_r <= {quo_r[fbpa_pkg::IDX_W-2:0], ~trial[fbpa_pkg::REM_W]};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/fbpa_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_regs
// configuration registers, derived block size and pool span
// ----------------------------------------------------------------------------
module fbpa_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0] pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0] prdata,
  output fbpa_pkg::cfg_t               cfg
);

  logic                          enabled_r;
  logic [fbpa_pkg::ADDR_W-1:0]   base_r;
  logic [fbpa_pkg::WORDS_W-1:0]  words_r;
  logic [fbpa_pkg::CNT_W-1:0]    count_r;
  logic                          rebuild_r;
  logic [fbpa_pkg::SPAN_W-1:0]   span_r;
  logic [fbpa_pkg::SPAN_W-1:0]   span_nxt;
  logic [fbpa_pkg::WORDS_W-1:0]  words_eff;
  logic [fbpa_pkg::BYTES_W-1:0]  bytes;
  logic [fbpa_pkg::CNT_W-1:0]    cnt_eff;
  logic [fbpa_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_fire;

  assign reg_idx = paddr[fbpa_pkg::PADDR_W-1:2];
  assign wr_fire = psel & penable & pwrite;

  // register writes, every write asks for a list rebuild
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      base_r    <= '0;
      words_r   <= fbpa_pkg::WORDS_W'(1);
      count_r   <= fbpa_pkg::CNT_W'(1);
      rebuild_r <= 1'b0;
    end else begin
      rebuild_r <= wr_fire;
      if (wr_fire) begin
        case (reg_idx)
          fbpa_pkg::REG_ENABLE: enabled_r <= pwdata[0];
          fbpa_pkg::REG_BASE:   base_r    <= pwdata;
          fbpa_pkg::REG_WORDS:  words_r   <= pwdata[fbpa_pkg::WORDS_W-1:0];
          fbpa_pkg::REG_COUNT:  count_r   <= pwdata[fbpa_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // zero size acts as one word, count clamps to capacity
  always_comb begin
    words_eff = (words_r == '0) ? fbpa_pkg::WORDS_W'(1) : words_r;
    bytes     = {words_eff, 2'b00};
    cnt_eff   = (count_r > fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS)) ?
                fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) : count_r;
    span_nxt  = fbpa_pkg::SPAN_W'(cnt_eff) * fbpa_pkg::SPAN_W'(bytes);
  end

  // pool span in bytes, registered from the written setup
  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  // read back
  always_comb begin
    case (reg_idx)
      fbpa_pkg::REG_ENABLE: prdata = fbpa_pkg::PDATA_W'(enabled_r);
      fbpa_pkg::REG_BASE:   prdata = base_r;
      fbpa_pkg::REG_WORDS:  prdata = fbpa_pkg::PDATA_W'(words_r);
      fbpa_pkg::REG_COUNT:  prdata = fbpa_pkg::PDATA_W'(count_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.enabled = enabled_r;
  assign cfg.base    = base_r;
  assign cfg.bytes   = bytes;
  assign cfg.cnt     = cnt_eff;
  assign cfg.span    = span_r;
  assign cfg.rebuild = rebuild_r;

endmodule

/* src/fbpa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker
// port-level checks on the block pool allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [31:0]                  out_block_address,
  input logic [1:0]                   out_status,
  input logic [8:0]                   out_used_count,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite
);

  // a waiting result holds its payload
  `FBPA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_block_address) && $stable(out_status) && $stable(out_used_count), "stalled result item changed")

  // a failed request reports address zero
  `FBPA_ASSERT_IMP(a_fail_zero, out_valid && (out_status != fbpa_pkg::ST_OK), out_block_address == '0, "failed item carries a block address")

  // only one item in flight: the input closes right after an accept
  `FBPA_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while one is in flight")

  // a register write holds off the input
  `FBPA_ASSERT_IMP(a_cfg_hold, cfg_psel && cfg_penable && cfg_pwrite, in_stall, "item accepted during a register write")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

/* bench/fixed_block_pool_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// self-checking bench for the block pool allocator: a queue-fed driver sends
// get and release items, a shadow free list predicts every reply, and a
// monitor compares replies field by field across several pool setups and
// idle patterns, including a long output hold that backs up the input
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int END_CYCLES  = 20;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
  } pool_request_t;

  typedef struct packed {
    logic [31:0]       block_address;
    fbpa_pkg::status_t status;
    logic [8:0]        used_count;
    logic              head_valid;
  } pool_reply_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block ports
  logic                           in_valid           = 1'b0;
  logic                           in_stall;
  logic                           in_command         = fbpa_pkg::CMD_GET;
  logic [31:0]                    in_release_address = '0;
  logic                           out_valid;
  logic                           out_stall          = 1'b0;
  logic [31:0]                    out_block_address;
  logic [1:0]                     out_status;
  logic [8:0]                     out_used_count;
  logic                           out_head_valid;
  logic                           cfg_psel           = 1'b0;
  logic                           cfg_penable        = 1'b0;
  logic                           cfg_pwrite         = 1'b0;
  logic [fbpa_pkg::PADDR_W-1:0]   cfg_paddr          = '0;
  logic [fbpa_pkg::PDATA_W-1:0]   cfg_pwdata         = '0;
  logic [fbpa_pkg::PDATA_W-1:0]   cfg_prdata;
  logic                           cfg_pready;

  // traffic bookkeeping
  pool_request_t requests_to_send[$];
  pool_reply_t   pool_replies_due[$];
  int            requests_queued = 0;
  int            replies_seen    = 0;
  int            mismatch_count  = 0;
  int            quiet_cycles    = 0;
  int            send_idle_pct   = 0;
  int            recv_stall_pct  = 0;
  logic          hold_request    = 1'b0;
  logic          hold_done       = 1'b0;
  int            hold_left       = 0;

  // shadow pool: setup as written, derived sizes and the free list
  logic        m_enabled;
  logic [31:0] m_base;
  logic [13:0] m_words;
  logic [8:0]  m_count;
  logic [15:0] m_bytes;
  logic [8:0]  m_cnt;
  logic [8:0]  m_link[fbpa_pkg::MAX_BLOCKS];
  logic [8:0]  m_head;
  logic [8:0]  m_used;

  fixed_block_pool_allocator dut (.*);

  always #2 clk = ~clk;

  // relink every block in order and clear the used count
  function automatic void pool_rebuild();
    m_cnt   = (m_count > 9'(fbpa_pkg::MAX_BLOCKS)) ? 9'(fbpa_pkg::MAX_BLOCKS) : m_count;
    m_bytes = {((m_words == 14'd0) ? 14'd1 : m_words), 2'b00};
    for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++)
      m_link[i] = (i + 1 < int'(m_cnt)) ? 9'(i + 1) : fbpa_pkg::LINK_END;
    m_head = (m_cnt != 9'd0) ? 9'd0 : fbpa_pkg::LINK_END;
    m_used = '0;
  endfunction

  function automatic void pool_configure(logic [fbpa_pkg::REG_IDX_W-1:0] idx,
                                         logic [31:0] value);
    case (idx)
      fbpa_pkg::REG_ENABLE: m_enabled = value[0];
      fbpa_pkg::REG_BASE:   m_base    = value;
      fbpa_pkg::REG_WORDS:  m_words   = value[13:0];
      fbpa_pkg::REG_COUNT:  m_count   = value[8:0];
      default: ;
    endcase
    pool_rebuild();
  endfunction

  // serve one request against the shadow free list
  function automatic pool_reply_t pool_serve(logic command, logic [31:0] address);
    pool_reply_t r;
    logic [31:0] offset;
    logic [31:0] idx;
    logic [47:0] span;
    r.block_address = '0;
    r.status        = fbpa_pkg::ST_OK;
    span            = 48'(m_cnt) * 48'(m_bytes);
    if (!m_enabled) begin
      r.status = fbpa_pkg::ST_BAD_POOL;
    end else if (command == fbpa_pkg::CMD_GET) begin
      if (m_head >= m_cnt) begin
        r.status = fbpa_pkg::ST_EMPTY;
      end else begin
        r.block_address = m_base + 32'(m_head) * 32'(m_bytes);
        m_head          = m_link[m_head[7:0]];
        if (m_used < m_cnt) m_used++;
      end
    end else begin
      offset = address - m_base;
      if (48'(offset) >= span) begin
        r.status = fbpa_pkg::ST_BAD_PTR;
      end else begin
        // round down to the block start and push it on the head
        idx                = offset / 32'(m_bytes);
        r.block_address    = m_base + idx * 32'(m_bytes);
        m_link[idx[7:0]]   = m_head;
        m_head             = idx[8:0];
        if (m_used != 9'd0) m_used--;
      end
    end
    r.used_count = m_used;
    r.head_valid = (m_head < m_cnt);
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // sender: holds each item until taken, idles at random between items
  always @(posedge clk) begin : drive_requests
    pool_request_t nxt;
    logic          taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) pool_replies_due.push_back(pool_serve(in_command, in_release_address));
      if (!in_valid || taken) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt                = requests_to_send.pop_front();
          in_valid           <= 1'b1;
          in_command         <= nxt.command;
          in_release_address <= nxt.address;
        end else begin
          in_valid           <= 1'b0;
          in_command         <= 1'($urandom);
          in_release_address <= $urandom;
        end
      end
    end
  end

  // receiver: checks each reply, stalls at random or for one long hold
  always @(posedge clk) begin : check_replies
    pool_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pool_replies_due.size() == 0) begin
          flag_mismatch("reply with no request outstanding");
        end else begin
          want = pool_replies_due.pop_front();
          replies_seen++;
          if (out_block_address !== want.block_address)
            flag_mismatch($sformatf("block_address got %h want %h",
                                    out_block_address, want.block_address));
          if (out_status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_used_count !== want.used_count)
            flag_mismatch($sformatf("used_count got %0d want %0d",
                                    out_used_count, want.used_count));
          if (out_head_valid !== want.head_valid)
            flag_mismatch($sformatf("head_valid got %b want %b",
                                    out_head_valid, want.head_valid));
        end
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apb write: setup cycle, then access cycle
  task automatic write_reg(logic [fbpa_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    pool_configure(idx, value);
  endtask

  task automatic set_pool(logic en, logic [31:0] base, logic [13:0] words, logic [8:0] count);
    write_reg(fbpa_pkg::REG_ENABLE, {31'd0, en});
    write_reg(fbpa_pkg::REG_BASE, base);
    write_reg(fbpa_pkg::REG_WORDS, {18'd0, words});
    write_reg(fbpa_pkg::REG_COUNT, {23'd0, count});
  endtask

  task automatic queue_request(logic command, logic [31:0] address);
    requests_to_send.push_back('{command: command, address: address});
    requests_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (replies_seen != requests_queued);
  endtask

  // runs of mostly gets, mostly in-pool releases or an even mix, with some stray addresses
  task automatic queue_random(int n);
    int          trend;
    int          get_pct;
    int          pick;
    int          idx;
    logic [31:0] addr;
    logic [31:0] span;
    trend = 2;
    span  = 32'(m_cnt) * 32'(m_bytes);
    for (int k = 0; k < n; k++) begin
      if (k % 8 == 0) trend = $urandom_range(2);
      get_pct = (trend == 0) ? 80 : (trend == 1) ? 20 : 50;
      pick    = $urandom_range(99);
      if (pick < get_pct) begin
        queue_request(fbpa_pkg::CMD_GET, $urandom);
      end else if (pick < 90 && m_cnt != 9'd0) begin
        idx  = $urandom_range(int'(m_cnt) - 1);
        addr = m_base + 32'(idx) * 32'(m_bytes) + $urandom_range(int'(m_bytes) - 1);
        queue_request(fbpa_pkg::CMD_RELEASE, addr);
      end else begin
        case ($urandom_range(3))
          0:       addr = $urandom;
          1:       addr = m_base - 32'd1;
          2:       addr = m_base + span;
          default: addr = m_base + span - 32'd1;
        endcase
        queue_request(fbpa_pkg::CMD_RELEASE, addr);
      end
    end
  endtask

  task automatic run_phase(logic en, logic [31:0] base, logic [13:0] words,
                           logic [8:0] count, int send_pct, int stall_pct, int n, bit hold);
    set_pool(en, base, words, count);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
    if (hold) hold_request <= 1'b1;
    queue_random(n);
    wait_drained();
  endtask

  // stimulus
  initial begin
    m_enabled = 1'b0;
    m_base    = '0;
    m_words   = 14'd1;
    m_count   = 9'd1;
    pool_rebuild();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // pool not created yet: every request refused
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    wait_drained();

    // three 8-byte blocks: run dry, stray pointers, repeated release, floor at zero
    set_pool(1'b1, 32'h0000_0100, 14'd2, 9'd3);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_010F);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_00FF);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0118);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0117);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0117);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0100);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    wait_drained();

    // no blocks at all, zero block size
    set_pool(1'b1, 32'h0000_0100, 14'd0, 9'd0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0100);
    wait_drained();

    // misaligned base with zero block size
    set_pool(1'b1, 32'h0000_0003, 14'd0, 9'd2);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0008);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    wait_drained();

    // pool wrapping past the top of the address space
    set_pool(1'b1, 32'hFFFF_FFF8, 14'd1, 9'd4);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_GET, 32'h0);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'h0000_0005);
    queue_request(fbpa_pkg::CMD_RELEASE, 32'hFFFF_FFF7);
    wait_drained();

    // random phases over setups and idle patterns
    run_phase(1'b1, 32'h0000_1000, 14'd4, 9'd8, 0, 0, 50, 1'b0);
    run_phase(1'b1, 32'h0000_0003, 14'd1, 9'd256, 83, 0, 50, 1'b0);
    run_phase(1'b1, 32'hFFFF_FF00, 14'd16, 9'd20, 0, 83, 50, 1'b0);
    run_phase(1'b1, $urandom & 32'hFFFF_FFFC, 14'd16383, 9'd256, 29, 29, 30, 1'b0);
    run_phase(1'b1, $urandom, 14'd0, 9'd3, 0, 0, 50, 1'b1);
    run_phase(1'b1, $urandom & 32'hFFFF_FFFC, 14'd7, 9'd300, 29, 29, 50, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFC, 14'd1, 9'd511, 83, 0, 50, 1'b0);
    run_phase(1'b1, 32'h0000_0000, 14'd2, 9'd1, 0, 83, 40, 1'b0);
    run_phase(1'b1, $urandom, 14'($urandom), 9'd0, 29, 29, 15, 1'b0);
    run_phase(1'b0, $urandom, 14'($urandom), 9'd5, 0, 0, 15, 1'b0);

    repeat (END_CYCLES) @(posedge clk);
    if (pool_replies_due.size() != 0) flag_mismatch("replies still outstanding at end");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/fbpa_pkg.sv
src/fbpa_link_mem.sv
src/fbpa_div.sv
src/fbpa_regs.sv
src/fixed_block_pool_allocator.sv
src/fbpa_checker.sv
bench/fixed_block_pool_allocator_tb.sv
